// ===== hw/rtl/bqf_pkg.sv =====
// ----------------------------------------------------------------------------
// bqf_pkg
// Widths, codes, control word layout and microcode for the biquad core.
// ----------------------------------------------------------------------------
package bqf_pkg;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int STATE_W  = 48;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W   = 4;
  localparam int ACC_SHIFT = 7;
  localparam int OUT_SHIFT = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_UNITY = 32'sh0100_0000;

  localparam logic signed [ACC_W-1:0] RND_HALF  = 58'sd65536;
  localparam logic signed [ACC_W-1:0] Y_MAX     = 58'sd8388607;
  localparam logic signed [ACC_W-1:0] Y_MIN     = -58'sd8388608;
  localparam logic signed [ACC_W-1:0] STATE_MAX = 58'sd140737488355327;
  localparam logic signed [ACC_W-1:0] STATE_MIN = -58'sd140737488355328;

  typedef enum logic [2:0] {
    COEF_SEL_B0,
    COEF_SEL_B1,
    COEF_SEL_B2,
    COEF_SEL_A1,
    COEF_SEL_A2
  } coef_sel_t;

  typedef enum logic {
    OPND_X,
    OPND_Y
  } opnd_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_SHADD
  } acc_op_t;

  typedef enum logic [1:0] {
    Z_ONE,
    Z_TWO,
    Z_NONE
  } z_sel_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  typedef struct packed {
    logic      take_in;
    logic      mul_en;
    coef_sel_t coef_sel;
    opnd_sel_t opnd_sel;
    acc_op_t   acc_op;
    z_sel_t    z_sel;
    logic      y_en;
    logic      wr_one;
    logic      wr_two;
    logic      emit;
    hold_t     hold;
    logic      last;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{
    take_in:  1'b0,
    mul_en:   1'b0,
    coef_sel: COEF_SEL_B0,
    opnd_sel: OPND_X,
    acc_op:   ACC_HOLD,
    z_sel:    Z_NONE,
    y_en:     1'b0,
    wr_one:   1'b0,
    wr_two:   1'b0,
    emit:     1'b0,
    hold:     HOLD_NONE,
    last:     1'b0
  };

  // one control word per step of the program
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    c = CTL_NOP;
    unique case (step)
      4'd0: begin
        c.take_in = 1'b1;
        c.hold    = HOLD_IN;
      end
      4'd1: begin
        c.mul_en = 1'b1; c.coef_sel = COEF_SEL_B0; c.opnd_sel = OPND_X;
      end
      4'd2: begin
        c.acc_op = ACC_LOAD;
        c.mul_en = 1'b1; c.coef_sel = COEF_SEL_B1; c.opnd_sel = OPND_X;
      end
      4'd3: begin
        c.acc_op = ACC_SHADD; c.z_sel = Z_ONE;
      end
      4'd4: begin
        c.y_en   = 1'b1;
        c.acc_op = ACC_LOAD;
      end
      4'd5: begin
        c.mul_en = 1'b1; c.coef_sel = COEF_SEL_A1; c.opnd_sel = OPND_Y;
      end
      4'd6: begin
        c.acc_op = ACC_SUB;
        c.mul_en = 1'b1; c.coef_sel = COEF_SEL_B2; c.opnd_sel = OPND_X;
      end
      4'd7: begin
        c.acc_op = ACC_SHADD; c.z_sel = Z_TWO;
      end
      4'd8: begin
        c.wr_one = 1'b1;
        c.acc_op = ACC_LOAD;
        c.mul_en = 1'b1; c.coef_sel = COEF_SEL_A2; c.opnd_sel = OPND_Y;
      end
      4'd9: begin
        c.acc_op = ACC_SUB;
      end
      4'd10: begin
        c.acc_op = ACC_SHADD; c.z_sel = Z_NONE;
      end
      4'd11: begin
        c.wr_two = 1'b1;
        c.emit   = 1'b1;
        c.hold   = HOLD_OUT;
        c.last   = 1'b1;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/bqf_if.sv =====
// ----------------------------------------------------------------------------
// bqf_if
// Valid/ready stream interfaces for sample beats into and out of the core.
// ----------------------------------------------------------------------------
interface bqf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [bqf_pkg::CHAN_W-1:0]           channel;
  logic signed [bqf_pkg::SAMPLE_W-1:0]  sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface bqf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [bqf_pkg::CHAN_W-1:0]           channel_out;
  logic signed [bqf_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                 clipped;

  modport source (output valid, output channel_out, output sample_out, output clipped,
                  input ready);
  modport sink   (input valid, input channel_out, input sample_out, input clipped,
                  output ready);
endinterface

// ===== hw/rtl/bqf_sequencer.sv =====
// ----------------------------------------------------------------------------
// bqf_sequencer
// Step counter over the microcode table, with wait-in-place conditions.
// ----------------------------------------------------------------------------
module bqf_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_busy,
  output bqf_pkg::ctl_t ctl
);

  logic [bqf_pkg::STEP_W-1:0] step;
  logic [bqf_pkg::STEP_W-1:0] step_next;
  logic                       stay;

  assign ctl = bqf_pkg::ucode(step);

  always_comb begin
    unique case (ctl.hold)
      bqf_pkg::HOLD_IN:  stay = !in_valid;
      bqf_pkg::HOLD_OUT: stay = out_busy;
      default:           stay = 1'b0;
    endcase
    priority if (stay) begin
      step_next = step;
    end else if (ctl.last) begin
      step_next = '0;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hw/rtl/bqf_datapath.sv =====
// ----------------------------------------------------------------------------
// bqf_datapath
// Coefficients, shared multiplier, accumulator, delay memories and result.
// ----------------------------------------------------------------------------
module bqf_datapath #(
  parameter int CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bqf_pkg::COEF_W-1:0]           cfg_data,
  input  bqf_pkg::ctl_t                        ctl,
  input  logic                                 in_fire,
  input  logic [bqf_pkg::CHAN_W-1:0]           in_channel,
  input  logic signed [bqf_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 out_load,
  output logic [bqf_pkg::CHAN_W-1:0]           out_channel,
  output logic signed [bqf_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                 out_clipped
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [bqf_pkg::COEF_W-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [bqf_pkg::SAMPLE_W-1:0] x_reg;
  logic signed [bqf_pkg::SAMPLE_W-1:0] y_reg;
  logic                                clip_reg;
  logic [bqf_pkg::CHAN_W-1:0]          ch_reg;
  logic                                ch_ok;
  logic [ADDR_W-1:0]                   wr_addr;
  logic [ADDR_W-1:0]                   rd_addr;

  logic signed [bqf_pkg::STATE_W-1:0]  mem_one [CHANNELS];
  logic signed [bqf_pkg::STATE_W-1:0]  mem_two [CHANNELS];
  logic [CHANNELS-1:0]                 vld_one, vld_two;
  logic signed [bqf_pkg::STATE_W-1:0]  rd_one, rd_two;
  logic                                rdv_one, rdv_two;

  logic signed [bqf_pkg::COEF_W-1:0]   mul_a;
  logic signed [bqf_pkg::SAMPLE_W-1:0] mul_b;
  logic signed [bqf_pkg::PROD_W-1:0]   prod;
  logic signed [bqf_pkg::ACC_W-1:0]    acc;
  logic signed [bqf_pkg::ACC_W-1:0]    zval;
  logic signed [bqf_pkg::ACC_W-1:0]    y_full;
  logic signed [bqf_pkg::SAMPLE_W-1:0] y_sat;
  logic                                y_clip;
  logic signed [bqf_pkg::STATE_W-1:0]  st_sat;

  assign rd_addr = ADDR_W'(in_channel);
  assign wr_addr = ADDR_W'(ch_reg);

  // coefficient registers, passthrough after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= bqf_pkg::COEF_UNITY;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bqf_pkg::CFG_B0: coef_b0 <= cfg_data;
        bqf_pkg::CFG_B1: coef_b1 <= cfg_data;
        bqf_pkg::CFG_B2: coef_b2 <= cfg_data;
        bqf_pkg::CFG_A1: coef_a1 <= cfg_data;
        bqf_pkg::CFG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the input beat and fetch both delay words of its channel
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_reg   <= in_sample;
      ch_reg  <= in_channel;
      ch_ok   <= 32'(in_channel) < CHANNELS;
      rd_one  <= mem_one[rd_addr];
      rd_two  <= mem_two[rd_addr];
      rdv_one <= vld_one[rd_addr];
      rdv_two <= vld_two[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_one && ch_ok) begin
      mem_one[wr_addr] <= st_sat;
    end
    if (ctl.wr_two && ch_ok) begin
      mem_two[wr_addr] <= st_sat;
    end
  end

  // a never-written entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_one <= '0;
      vld_two <= '0;
    end else begin
      if (ctl.wr_one && ch_ok) begin
        vld_one[wr_addr] <= 1'b1;
      end
      if (ctl.wr_two && ch_ok) begin
        vld_two[wr_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    unique case (ctl.coef_sel)
      bqf_pkg::COEF_SEL_B0: mul_a = coef_b0;
      bqf_pkg::COEF_SEL_B1: mul_a = coef_b1;
      bqf_pkg::COEF_SEL_B2: mul_a = coef_b2;
      bqf_pkg::COEF_SEL_A1: mul_a = coef_a1;
      bqf_pkg::COEF_SEL_A2: mul_a = coef_a2;
      default:              mul_a = '0;
    endcase
    unique case (ctl.opnd_sel)
      bqf_pkg::OPND_X: mul_b = x_reg;
      bqf_pkg::OPND_Y: mul_b = y_reg;
      default:         mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= bqf_pkg::PROD_W'(mul_a) * bqf_pkg::PROD_W'(mul_b);
    end
  end

  always_comb begin
    unique case (ctl.z_sel)
      bqf_pkg::Z_ONE:
        zval = (rdv_one && ch_ok) ? bqf_pkg::ACC_W'(rd_one) : '0;
      bqf_pkg::Z_TWO:
        zval = (rdv_two && ch_ok) ? bqf_pkg::ACC_W'(rd_two) : '0;
      default:
        zval = '0;
    endcase
  end

  // arithmetic shift right floors, as the product scaling needs
  always_ff @(posedge clk) begin
    unique case (ctl.acc_op)
      bqf_pkg::ACC_LOAD:  acc <= bqf_pkg::ACC_W'(prod);
      bqf_pkg::ACC_SUB:   acc <= acc - bqf_pkg::ACC_W'(prod);
      bqf_pkg::ACC_SHADD: acc <= (acc >>> bqf_pkg::ACC_SHIFT) + zval;
      default:            acc <= acc;
    endcase
  end

  // round half up to Q1.23, then clamp the sample and the state word
  always_comb begin
    y_full = (acc + bqf_pkg::RND_HALF) >>> bqf_pkg::OUT_SHIFT;
    priority if (y_full > bqf_pkg::Y_MAX) begin
      y_sat  = bqf_pkg::SAMPLE_W'(bqf_pkg::Y_MAX);
      y_clip = 1'b1;
    end else if (y_full < bqf_pkg::Y_MIN) begin
      y_sat  = bqf_pkg::SAMPLE_W'(bqf_pkg::Y_MIN);
      y_clip = 1'b1;
    end else begin
      y_sat  = y_full[bqf_pkg::SAMPLE_W-1:0];
      y_clip = 1'b0;
    end
    priority if (acc > bqf_pkg::STATE_MAX) begin
      st_sat = bqf_pkg::STATE_W'(bqf_pkg::STATE_MAX);
    end else if (acc < bqf_pkg::STATE_MIN) begin
      st_sat = bqf_pkg::STATE_W'(bqf_pkg::STATE_MIN);
    end else begin
      st_sat = acc[bqf_pkg::STATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.y_en) begin
      y_reg    <= y_sat;
      clip_reg <= y_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= ch_reg;
      out_sample  <= y_reg;
      out_clipped <= clip_reg;
    end
  end

endmodule

// ===== hw/rtl/biquad_tdf2_filter_core.sv =====
// ----------------------------------------------------------------------------
// biquad_tdf2_filter_core
// Multichannel biquad IIR section, transposed direct form II, microcoded.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream carries one sample beat (channel, Q1.23 sample_in); out_stream
//   returns one beat per input (channel_out, saturated sample_out, clipped).
//   Coefficients b0, b1, b2, a1, a2 (Q8.24) are written through cfg_we,
//   cfg_index and cfg_data while the core is idle; indexes past a2 are dropped.
//   Each sample runs a 12-step program over one shared 32x24 multiplier and
//   one accumulator, five products in turn, walked by the microcode step
//   counter; a new beat is taken only on the program's fetch step.
//   The next beat is accepted while a finished result still waits in the
//   output register; a stalled receiver holds the program on its last step,
//   so at most one result waits and one item is in flight.
//   Reset restores passthrough coefficients (b0 = 1.0, others zero) and
//   clears per-channel valid bits, so every delay word reads as zero until
//   its channel is first written. Channels at or above CHANNELS filter with
//   zero state and leave the state alone.
// ----------------------------------------------------------------------------
module biquad_tdf2_filter_core #(
  parameter int CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bqf_pkg::COEF_W-1:0]     cfg_data,
  bqf_in_if.sink                         in_stream,
  bqf_out_if.source                      out_stream
);

  bqf_pkg::ctl_t ctl;
  logic          in_fire;
  logic          out_load;
  logic          out_valid;
  logic          out_busy;

  // result register is occupied and not being taken this cycle
  assign out_busy = out_valid && !out_stream.ready;

  // accept only on the program's fetch step, never while in reset
  assign in_stream.ready = ctl.take_in && !rst;
  assign in_fire         = in_stream.valid && ctl.take_in && !rst;

  // load the result once the output register is free
  assign out_load = ctl.emit && !out_busy;

  bqf_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  bqf_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctl         (ctl),
    .in_fire     (in_fire),
    .in_channel  (in_stream.channel),
    .in_sample   (in_stream.sample_in),
    .out_load    (out_load),
    .out_channel (out_stream.channel_out),
    .out_sample  (out_stream.sample_out),
    .out_clipped (out_stream.clipped)
  );

  // hold the beat until taken; a new load replaces one taken this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_stream.valid = out_valid;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for biquad_tdf2_filter_core. Sample beats are driven on
// the input stream with random gaps and pushed through a bit-exact fixed-point
// model of the TDF-II section. Result beats are compared with the model in
// order. Coefficient sets are swapped between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int          NCHAN           = 8;
  localparam int unsigned STALL_LIMIT     = 4000;  // quiet cycles before giving up
  localparam int unsigned HOLD_OFF_CYCLES = 300;   // long receiver back-pressure
  localparam int unsigned SETTLE_CYCLES   = 4;     // margin before a coefficient load
  localparam int unsigned TAIL_CYCLES     = 24;    // about two sample programs
  localparam int unsigned PHASE_BEATS     = 70;

  localparam logic signed [bqf_pkg::SAMPLE_W-1:0] X_MAX = 24'sh7F_FFFF;
  localparam logic signed [bqf_pkg::SAMPLE_W-1:0] X_MIN = 24'sh80_0000;

  // Q8.24 values used by the directed and shaped phases
  localparam logic [bqf_pkg::COEF_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [bqf_pkg::COEF_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [bqf_pkg::COEF_W-1:0] Q_HALF = 32'h0080_0000;
  localparam logic [bqf_pkg::COEF_W-1:0] Q_QRTR = 32'h0040_0000;
  localparam logic [bqf_pkg::COEF_W-1:0] Q_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic [bqf_pkg::CHAN_W-1:0]          channel;
    logic signed [bqf_pkg::SAMPLE_W-1:0] sample;
    logic                                clipped;
  } filt_result_t;

  // --------------------------------------------------------------------------
  // Fixed-point model of the section plus the queue of filtered samples that
  // are still owed by the core.
  // --------------------------------------------------------------------------
  class biquad_scoreboard;
    longint       coef [5];
    longint       tap1_state [NCHAN];
    longint       tap2_state [NCHAN];
    filt_result_t owed_q [$];
    int unsigned  errors;

    function new();
      coef[bqf_pkg::CFG_B0] = bqf_pkg::COEF_UNITY;
      coef[bqf_pkg::CFG_B1] = 0;
      coef[bqf_pkg::CFG_B2] = 0;
      coef[bqf_pkg::CFG_A1] = 0;
      coef[bqf_pkg::CFG_A2] = 0;
      foreach (tap1_state[i]) begin
        tap1_state[i] = 0;
        tap2_state[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_coef(logic [bqf_pkg::CFG_IDX_W-1:0] idx,
                           logic [bqf_pkg::COEF_W-1:0] data);
      // indexes past a2 are dropped by the core
      if (idx <= bqf_pkg::CFG_A2)
        coef[idx] = $signed(data);
    endfunction

    function void note_sample(logic [bqf_pkg::CHAN_W-1:0] ch,
                              logic signed [bqf_pkg::SAMPLE_W-1:0] x);
      longint       xs, z1, z2, acc, y, n1, n2;
      bit           live, clip;
      filt_result_t r;
      xs   = x;
      live = (ch < NCHAN);
      z1   = live ? tap1_state[ch] : 0;
      z2   = live ? tap2_state[ch] : 0;
      // y: drop to 40 fraction bits, add z1, round half up to Q1.23
      acc  = ((coef[bqf_pkg::CFG_B0] * xs) >>> bqf_pkg::ACC_SHIFT) + z1;
      y    = (acc + bqf_pkg::RND_HALF) >>> bqf_pkg::OUT_SHIFT;
      clip = 1'b0;
      if (y > bqf_pkg::Y_MAX) begin
        y    = bqf_pkg::Y_MAX;
        clip = 1'b1;
      end else if (y < bqf_pkg::Y_MIN) begin
        y    = bqf_pkg::Y_MIN;
        clip = 1'b1;
      end
      // feedback runs on the saturated output; z1' takes the old z2
      n1 = ((coef[bqf_pkg::CFG_B1] * xs - coef[bqf_pkg::CFG_A1] * y)
            >>> bqf_pkg::ACC_SHIFT) + z2;
      n2 = (coef[bqf_pkg::CFG_B2] * xs - coef[bqf_pkg::CFG_A2] * y)
           >>> bqf_pkg::ACC_SHIFT;
      if (n1 > bqf_pkg::STATE_MAX) n1 = bqf_pkg::STATE_MAX;
      if (n1 < bqf_pkg::STATE_MIN) n1 = bqf_pkg::STATE_MIN;
      if (n2 > bqf_pkg::STATE_MAX) n2 = bqf_pkg::STATE_MAX;
      if (n2 < bqf_pkg::STATE_MIN) n2 = bqf_pkg::STATE_MIN;
      if (live) begin
        tap1_state[ch] = n1;
        tap2_state[ch] = n2;
      end
      r.channel = ch;
      r.sample  = y[bqf_pkg::SAMPLE_W-1:0];
      r.clipped = clip;
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [bqf_pkg::CHAN_W-1:0] ch,
                               logic signed [bqf_pkg::SAMPLE_W-1:0] y,
                               logic clip);
      filt_result_t r;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: ch=%0d y=%0d clip=%b", ch, y, clip);
        return;
      end
      r = owed_q.pop_front();
      if (ch !== r.channel || y !== r.sample || clip !== r.clipped) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected ch=%0d y=%0d clip=%b, got ch=%0d y=%0d clip=%b",
                   r.channel, $signed(r.sample), r.clipped, ch, y, clip);
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic                          cfg_we;
  logic [bqf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bqf_pkg::COEF_W-1:0]    cfg_data;

  always #5 clk = ~clk;

  bqf_in_if  in_stream ();
  bqf_out_if out_stream ();

  biquad_tdf2_filter_core #(
    .CHANNELS (NCHAN)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

  biquad_scoreboard board;

  bit hold_off_req;  // ask the receiver for one long back-pressure stretch
  bit steady_flow;   // no idling on either side while set

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // mostly back-to-back, sometimes a short gap, rarely a long gap
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // full-scale extremes, tiny values, small audio and full-range noise
  function automatic logic signed [bqf_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return X_MAX;
      1:       return X_MIN;
      2:       return bqf_pkg::SAMPLE_W'($urandom_range(0, 2)) - 24'd1;
      3, 4, 5: return bqf_pkg::SAMPLE_W'($urandom_range(0, 8191)) - 24'd4096;
      default: return bqf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // coefficient within +/-2.0, the usual range for a stable section
  function automatic logic [bqf_pkg::COEF_W-1:0] rand_coef_small();
    return bqf_pkg::COEF_W'($urandom_range(0, 32'h03FF_FFFF)) - 32'h0200_0000;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one sample beat and hold it until the core takes it. Valid is left
  // high so a following beat goes out back to back.
  task automatic push_sample(input logic [bqf_pkg::CHAN_W-1:0] ch,
                             input logic signed [bqf_pkg::SAMPLE_W-1:0] x);
    in_stream.valid     <= 1'b1;
    in_stream.channel   <= ch;
    in_stream.sample_in <= x;
    @(posedge clk);
    while (!in_stream.ready) @(posedge clk);
    board.note_sample(ch, x);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n != 0) begin
      in_stream.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every owed result is back, then a little more.
  task automatic wait_drained();
    in_stream.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable stays high across consecutive writes; the caller lowers it.
  task automatic write_reg(input logic [bqf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bqf_pkg::COEF_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_coef(idx, data);
  endtask

  // Load a full coefficient set, then poke an unused index with junk.
  task automatic load_coefs(input logic [bqf_pkg::COEF_W-1:0] b0, b1, b2, a1, a2);
    write_reg(bqf_pkg::CFG_B0, b0);
    write_reg(bqf_pkg::CFG_B1, b1);
    write_reg(bqf_pkg::CFG_B2, b2);
    write_reg(bqf_pkg::CFG_A1, a1);
    write_reg(bqf_pkg::CFG_A2, a2);
    write_reg(bqf_pkg::CFG_IDX_W'($urandom_range(bqf_pkg::CFG_A2 + 1,
                                                 2 ** bqf_pkg::CFG_IDX_W - 1)),
              $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned beats);
    for (int unsigned i = 0; i < beats; i++) begin
      push_sample(bqf_pkg::CHAN_W'($urandom_range(0, NCHAN - 1)), rand_sample());
      if (!steady_flow) pause_sender(gap_len());
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned run;
    bit          rdy;
    out_stream.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rdy          = 1'b0;
        run          = HOLD_OFF_CYCLES;
      end else if (steady_flow) begin
        rdy = 1'b1;
        run = 1;
      end else begin
        rdy = ($urandom_range(0, 2) != 0);
        run = rdy ? $urandom_range(1, 8) : 1 + gap_len();
      end
      out_stream.ready <= rdy;
      repeat (run) @(posedge clk);
    end
  end

  // check every result beat at the edge that moves it
  always @(posedge clk) begin
    if (!rst && out_stream.valid && out_stream.ready)
      board.check_result(out_stream.channel_out, out_stream.sample_out, out_stream.clipped);
  end

  // end the run when neither stream has moved a beat for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_stream.valid && in_stream.ready) || (out_stream.valid && out_stream.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    board        = new();
    hold_off_req = 1'b0;
    steady_flow  = 1'b0;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= bqf_pkg::CFG_B0;
    cfg_data            <= '0;
    in_stream.valid     <= 1'b0;
    in_stream.channel   <= '0;
    in_stream.sample_in <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Passthrough after reset: extremes, unit steps and alternating bit
    // patterns, one per channel.
    push_sample(3'd0, 24'sd0);
    push_sample(3'd1, X_MAX);
    push_sample(3'd2, X_MIN);
    push_sample(3'd3, 24'sd1);
    pause_sender(gap_len());
    push_sample(3'd4, -24'sd1);
    push_sample(3'd5, 24'sh55_5555);
    push_sample(3'd6, 24'shAA_AAAA);
    push_sample(3'd7, X_MAX);

    // Maximum gain: drive the output into both clip rails.
    wait_drained();
    load_coefs(Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
    push_sample(3'd0, X_MAX);
    push_sample(3'd1, X_MIN);
    push_sample(3'd2, 24'sd1);
    push_sample(3'd3, -24'sd1);

    // Most negative gain: min times min overflows positive.
    wait_drained();
    load_coefs(Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
    push_sample(3'd4, X_MIN);
    push_sample(3'd5, X_MAX);

    // Every tap live: impulses through both delay words, ringing on two
    // channels to show the state stays per channel.
    wait_drained();
    load_coefs(bqf_pkg::COEF_UNITY, Q_HALF, Q_QRTR, 32'hFF80_0000, Q_QRTR);
    push_sample(3'd6, 24'sh40_0000);
    push_sample(3'd7, X_MIN);
    push_sample(3'd6, 24'sd0);
    push_sample(3'd7, 24'sd0);
    push_sample(3'd6, 24'sd0);
    push_sample(3'd6, 24'sd0);
    push_sample(3'd7, 24'sd0);

    // Low-pass style section; halfway through, hold until the core is empty.
    wait_drained();
    load_coefs(32'd1132462, 32'd2264924, 32'd1132462, -32'sd19176357, 32'd6925635);
    run_phase(PHASE_BEATS / 2);
    wait_drained();
    run_phase(PHASE_BEATS / 2);

    // Small random coefficients. Start with a long receiver hold-off while
    // beats keep coming back to back, so the core fills and stalls its input.
    wait_drained();
    load_coefs(rand_coef_small(), rand_coef_small(), rand_coef_small(),
               rand_coef_small(), rand_coef_small());
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++)
      push_sample(bqf_pkg::CHAN_W'($urandom_range(0, NCHAN - 1)), rand_sample());
    run_phase(PHASE_BEATS - 12);

    // All coefficients at the positive extreme, then the negative extreme:
    // state words pin at their 48-bit limits.
    wait_drained();
    load_coefs(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    run_phase(PHASE_BEATS);
    wait_drained();
    load_coefs(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    run_phase(PHASE_BEATS);

    // Fully random coefficients.
    wait_drained();
    load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
    run_phase(PHASE_BEATS);

    // High-gain resonator close to the unit circle: frequent clipping.
    wait_drained();
    load_coefs(32'h0400_0000, Q_ZERO, 32'hFC00_0000, -32'sd33386660, 32'd16693330);
    run_phase(PHASE_BEATS);

    // Back to passthrough with no idling on either side.
    wait_drained();
    load_coefs(bqf_pkg::COEF_UNITY, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
    steady_flow = 1'b1;
    run_phase(PHASE_BEATS);
    steady_flow = 1'b0;

    // Drain, then watch a little longer for stray beats.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bqf_pkg.sv
hw/rtl/bqf_if.sv
hw/rtl/bqf_sequencer.sv
hw/rtl/bqf_datapath.sv
hw/rtl/biquad_tdf2_filter_core.sv
sim/tb.sv
